FILE: hw/rtl/salc_pkg.sv
// Shared types, codes and defaults for the set-associative LRU cache.
package salc_pkg;

	// Default geometry
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_ADDR_WIDTH   = 48;
	localparam int DEF_STAMP_WIDTH  = 32;

	localparam int COUNT_W = 32;
	localparam int CFG_W   = 5;

	// Access kinds
	typedef enum logic [1:0] {
		MODE_FETCH  = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_STORE  = 2'd2,
		MODE_MODIFY = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	typedef struct packed {
		logic [2:0] set_bits;
		logic [3:0] ways;
		logic [4:0] block_bits;
	} cfg_t;

	typedef struct packed {
		logic               was_hit;
		logic               was_miss;
		logic               was_eviction;
		logic               modify_second_hit;
		logic [COUNT_W-1:0] total_hits;
		logic [COUNT_W-1:0] total_misses;
		logic [COUNT_W-1:0] total_evictions;
	} result_t;

endpackage

FILE: hw/rtl/salc_fifo.sv
// Two-entry request queue between the front and back parts.
module salc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'(DEPTH));
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hw/rtl/salc_front.sv
// Front part: accepts requests, advances the access clock, splits the address.
module salc_front import salc_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
	parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH,
	parameter int ENTRY_W      = 2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH +
		STAMP_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  push,
	output logic [ENTRY_W-1:0]    push_data,
	input  logic                  q_full
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

	logic                   accept;
	logic [3:0]             sb;
	logic [ADDR_WIDTH-1:0]  shifted;
	logic [SET_W-1:0]       set_idx;
	logic [ADDR_WIDTH-1:0]  tag;
	logic [STAMP_WIDTH-1:0] clock_q;
	logic [STAMP_WIDTH-1:0] stamp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (mode != MODE_FETCH);

	// Clamp set bits to the array size
	always_comb begin
		if ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS)) sb = 4'(MAX_SET_BITS);
		else sb = {1'b0, cfg.set_bits};
	end

	// Address split
	assign shifted = address >> cfg.block_bits;
	assign set_idx = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
	assign tag     = address >> (6'(cfg.block_bits) + 6'(sb));
	assign stamp   = clock_q + STAMP_WIDTH'(1);

	assign push_data = {mode, set_idx, tag, stamp};

	// Access clock, every request including fetches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (accept) begin
			clock_q <= stamp;
		end
	end

endmodule

FILE: hw/rtl/salc_back.sv
// Back part: set row lookup, hit check, LRU victim pick, write-back and totals.
module salc_back import salc_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
	parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH,
	parameter int ENTRY_W      = 2 + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1) + ADDR_WIDTH +
		STAMP_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         cfg_ways,
	input  logic               q_empty,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output result_t            res
);

	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int ROWS  = 1 << MAX_SET_BITS;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [4:0] MAX_WAYS_C = 5'(MAX_WAYS);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tag_row_t;
	typedef logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] stamp_row_t;
	typedef logic [MAX_WAYS-1:0]                  valid_row_t;

	state_t state_q;

	// Set row memories
	tag_row_t   tag_mem   [ROWS];
	stamp_row_t stamp_mem [ROWS];
	valid_row_t valid_mem [ROWS];
	tag_row_t   tag_row_q;
	stamp_row_t stamp_row_q;
	valid_row_t valid_row_q;
	tag_row_t   tag_row_nxt;
	stamp_row_t stamp_row_nxt;
	valid_row_t valid_row_nxt;

	// Valid row clearing after reset
	logic [SET_W-1:0] clr_idx_q;
	logic             clr_last;

	// Request being worked on
	logic [1:0]             mode_q;
	logic [SET_W-1:0]       set_q;
	logic [ADDR_WIDTH-1:0]  tag_q;
	logic [STAMP_WIDTH-1:0] stamp_q;

	logic [1:0]             q_mode;
	logic [SET_W-1:0]       q_set;
	logic [ADDR_WIDTH-1:0]  q_tag;
	logic [STAMP_WIDTH-1:0] q_stamp;

	logic [COUNT_W-1:0] hits_q, misses_q, evicts_q;
	logic [COUNT_W-1:0] hits_nxt, misses_nxt, evicts_nxt;

	logic                   out_valid_q;
	result_t                res_q;

	logic [4:0]             ways_eff;
	logic [MAX_WAYS-1:0]    in_use;
	logic [MAX_WAYS-1:0]    vrow;
	logic [MAX_WAYS-1:0]    match;
	logic                   hit;
	logic [WAY_W-1:0]       hit_way;
	logic                   free_found;
	logic [WAY_W-1:0]       free_way;
	logic [WAY_W-1:0]       lru_way;
	logic [STAMP_WIDTH-1:0] lru_stamp;
	logic [WAY_W-1:0]       victim;
	logic                   evict;
	logic                   is_modify;
	logic                   exec_go;

	assign {q_mode, q_set, q_tag, q_stamp} = q_data;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign clr_last = (clr_idx_q == SET_W'(ROWS - 1));

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Clamp associativity
	always_comb begin
		if (cfg_ways == 4'd0) ways_eff = 5'd1;
		else if ({1'b0, cfg_ways} > MAX_WAYS_C) ways_eff = MAX_WAYS_C;
		else ways_eff = {1'b0, cfg_ways};
	end

	// Way compare, free search and LRU pick
	always_comb begin
		vrow       = valid_row_q;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = 5'(w) < ways_eff;
			match[w]  = vrow[w] && in_use[w] && (tag_row_q[w] == tag_q);
		end
		// Descending so the lowest way wins
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) hit_way = WAY_W'(w);
			if (in_use[w] && !vrow[w]) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
		end
		hit       = |match;
		lru_way   = '0;
		lru_stamp = stamp_row_q[0];
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (stamp_row_q[w] < lru_stamp)) begin
				lru_way   = WAY_W'(w);
				lru_stamp = stamp_row_q[w];
			end
		end
		victim = free_found ? free_way : lru_way;
		evict  = !hit && !free_found;
	end

	// Row update and totals
	always_comb begin
		tag_row_nxt   = tag_row_q;
		stamp_row_nxt = stamp_row_q;
		valid_row_nxt = valid_row_q;
		if (hit) begin
			stamp_row_nxt[hit_way] = stamp_q;
		end else begin
			tag_row_nxt[victim]   = tag_q;
			stamp_row_nxt[victim] = stamp_q;
			valid_row_nxt[victim] = 1'b1;
		end
		is_modify  = (mode_q == MODE_MODIFY);
		hits_nxt   = hit ? sat_inc(hits_q) : hits_q;
		if (is_modify) hits_nxt = sat_inc(hits_nxt);
		misses_nxt = hit ? misses_q : sat_inc(misses_q);
		evicts_nxt = evict ? sat_inc(evicts_q) : evicts_q;
	end

	// Memory read on pop, clearing pass after reset, write-back on completion
	always_ff @(posedge clk) begin
		if (q_pop) begin
			tag_row_q   <= tag_mem[q_set];
			stamp_row_q <= stamp_mem[q_set];
			valid_row_q <= valid_mem[q_set];
		end
		if (state_q == ST_CLEAR) begin
			valid_mem[clr_idx_q] <= '0;
		end else if (exec_go) begin
			tag_mem[set_q]   <= tag_row_nxt;
			stamp_mem[set_q] <= stamp_row_nxt;
			valid_mem[set_q] <= valid_row_nxt;
		end
	end

	// Request capture and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			mode_q  <= q_mode;
			set_q   <= q_set;
			tag_q   <= q_tag;
			stamp_q <= q_stamp;
		end
		if (exec_go) begin
			res_q.was_hit           <= hit;
			res_q.was_miss          <= !hit;
			res_q.was_eviction      <= evict;
			res_q.modify_second_hit <= is_modify;
			res_q.total_hits        <= hits_nxt;
			res_q.total_misses      <= misses_nxt;
			res_q.total_evictions   <= evicts_nxt;
		end
	end

	// Control, clear index and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + SET_W'(1);
					if (clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_go) begin
				hits_q   <= hits_nxt;
				misses_q <= misses_nxt;
				evicts_q <= evicts_nxt;
			end
			if (exec_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

FILE: hw/rtl/set_assoc_lru_cache_sim.sv
// A data request passes the queue, the row read and the result register before out_valid
// rises. The back part takes the next data request only after the read then write-back of
// the set row memories for the last, and a stalled result holds it; fetches never reach it.
// A two-entry queue lets the front keep accepting while a result waits. Reset initialises
// control, access clock, totals and configuration, then a pass over every set row (64 by
// default) clears the valid rows; tag and stamp rows are never cleared.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
	parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  was_hit,
	output logic                  was_miss,
	output logic                  was_eviction,
	output logic                  modify_second_hit,
	output logic [COUNT_W-1:0]    total_hits,
	output logic [COUNT_W-1:0]    total_misses,
	output logic [COUNT_W-1:0]    total_evictions
);

	localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int ENTRY_W = 2 + SET_W + ADDR_WIDTH + STAMP_WIDTH;

	cfg_t               cfg_q;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;
	logic               q_full;
	logic               q_empty;
	result_t            res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits   <= 3'd0;
			cfg_q.ways       <= 4'd1;
			cfg_q.block_bits <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:   cfg_q.set_bits   <= cfg_data[2:0];
				CFG_WAYS:       cfg_q.ways       <= cfg_data[3:0];
				CFG_BLOCK_BITS: cfg_q.block_bits <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	salc_front #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.STAMP_WIDTH (STAMP_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.address  (address),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	salc_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (q_pop),
		.pop_data (q_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	salc_back #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.STAMP_WIDTH (STAMP_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_ways (cfg_q.ways),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	assign was_hit           = res.was_hit;
	assign was_miss          = res.was_miss;
	assign was_eviction      = res.was_eviction;
	assign modify_second_hit = res.modify_second_hit;
	assign total_hits        = res.total_hits;
	assign total_misses      = res.total_misses;
	assign total_evictions   = res.total_evictions;

endmodule

FILE: hw/rtl/salc_checker.sv
// Port-level checks on the cache top level, bound to it.
module salc_checker import salc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               was_hit,
	input logic               was_miss,
	input logic               was_eviction,
	input logic [COUNT_W-1:0] total_misses
);

	// A stalled result stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Exactly one of hit and miss
	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (was_hit != was_miss))
		else $error("hit and miss flags disagree");

	// Evictions only happen on misses
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_eviction |-> was_miss)
		else $error("eviction reported on a hit");

	// A miss is counted in the running total
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_miss |-> (total_misses != '0))
		else $error("miss not counted");

	// A stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(was_hit) && $stable(was_eviction) &&
			$stable(total_misses))
		else $error("result changed while stalled");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
